// ===== rtl/core/gzfp_pkg.sv =====
package gzfp_pkg;

    // parse phases of one gzip member
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_XLEN,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    // byte classes
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_PAYLOAD = 2'd1;
    localparam logic [1:0] CLS_TRAILER = 2'd2;
    localparam logic [1:0] CLS_DROP    = 2'd3;

    // error codes
    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_ID1    = 3'd1;
    localparam logic [2:0] ERR_ID2    = 3'd2;
    localparam logic [2:0] ERR_METHOD = 3'd3;
    localparam logic [2:0] ERR_RSVD   = 3'd4;
    localparam logic [2:0] ERR_XFL    = 3'd5;
    localparam logic [2:0] ERR_ISIZE  = 3'd6;

    // header constants
    localparam logic [7:0] GZ_ID1       = 8'd31;
    localparam logic [7:0] GZ_ID2       = 8'd139;
    localparam logic [7:0] GZ_CM        = 8'd8;
    localparam logic [7:0] GZ_RSVD_MASK = 8'he0;
    localparam logic [7:0] GZ_XFL_MAX   = 8'd2;
    localparam logic [7:0] GZ_XFL_FAST  = 8'd4;

    // flag bit positions within the kept FLG bits
    localparam int FLG_HCRC    = 1;
    localparam int FLG_EXTRA   = 2;
    localparam int FLG_NAME    = 3;
    localparam int FLG_COMMENT = 4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        payload_end;
        logic [31:0] inflated_size;
    } item_t;

    typedef struct packed {
        logic [1:0] byte_class;
        logic [7:0] data_out;
        logic       member_done;
        logic [2:0] error_code;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] byte_count;
        logic [4:0]  member_flags;
        logic [15:0] extra_length;
        logic [31:0] expected_size;
        logic [31:0] trailer_size;
        logic [2:0]  error_latch;
    } state_t;

    // first phase that applies after the one just finished
    function automatic phase_t next_phase(phase_t done, logic [4:0] flags,
                                          logic [15:0] xlen);
        phase_t p;
        if (done < PH_XLEN && flags[FLG_EXTRA])
            p = PH_XLEN;
        else if (done < PH_EXTRA && flags[FLG_EXTRA] && xlen != 16'd0)
            p = PH_EXTRA;
        else if (done < PH_NAME && flags[FLG_NAME])
            p = PH_NAME;
        else if (done < PH_COMMENT && flags[FLG_COMMENT])
            p = PH_COMMENT;
        else if (done < PH_HCRC && flags[FLG_HCRC])
            p = PH_HCRC;
        else
            p = PH_PAYLOAD;
        return p;
    endfunction

endpackage

// ===== rtl/core/gzip_member_frame_parser.sv =====
// channel  | valid         | stall         | payload (packed struct)
// ---------+---------------+---------------+-------------------------------------------
// item     | item_valid    | item_stall    | item   : data_byte, payload_end, inflated_size
// result   | result_valid  | result_stall  | result : byte_class, data_out, member_done,
//          |               |               |          error_code
//
// one beat in, one beat out; a beat is taken each cycle item_stall is low, its result showing
// the next cycle; each byte takes one pass through the phase logic into the result register
// rst_n clears the phase, counters, size and error state and empties the result register
// item_stall rises only while a result is held and result_stall is high
// an error sticks until reset; every later beat comes out as dropped with the error code

module gzip_member_frame_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  gzfp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output gzfp_pkg::result_t result
);

    gzfp_pkg::state_t  state_reg;
    gzfp_pkg::state_t  state_next;
    gzfp_pkg::result_t step_res;
    logic              accept;
    logic              out_busy;

    assign item_stall = out_busy;
    assign accept     = item_valid && !out_busy;

    // per-beat phase logic
    gzfp_step u_step (
        .st      (state_reg),
        .item    (item),
        .st_next (state_next),
        .res     (step_res)
    );

    // parser state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= gzfp_pkg::PH_HEADER;
            state_reg.byte_count    <= '0;
            state_reg.member_flags  <= '0;
            state_reg.extra_length  <= '0;
            state_reg.expected_size <= '0;
            state_reg.trailer_size  <= '0;
            state_reg.error_latch   <= gzfp_pkg::ERR_OK;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result register, decouples the two sides
    gzfp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .res_in       (step_res),
        .busy         (out_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/core/gzfp_step.sv =====
module gzfp_step (
    input  gzfp_pkg::state_t  st,
    input  gzfp_pkg::item_t   item,
    output gzfp_pkg::state_t  st_next,
    output gzfp_pkg::result_t res
);

    logic [15:0] bc_inc;
    logic [15:0] xlen_full;
    logic [31:0] tsz;
    logic [7:0]  b;

    always_comb
    begin
        b         = item.data_byte;
        bc_inc    = st.byte_count + 16'd1;
        xlen_full = {b, st.extra_length[7:0]};
        tsz       = st.trailer_size;
        if (st.byte_count >= 16'd4)
        begin
            tsz[{st.byte_count[1:0], 3'b000} +: 8] = b;
        end

        st_next         = st;
        res.byte_class  = gzfp_pkg::CLS_DROP;
        res.data_out    = item.payload_end ? 8'h00 : b;
        res.member_done = 1'b0;

        if (st.error_latch != gzfp_pkg::ERR_OK)
        begin
            // sticky error: drop everything
        end
        else if (item.payload_end)
        begin
            if (st.phase == gzfp_pkg::PH_PAYLOAD)
            begin
                st_next.expected_size = item.inflated_size;
                st_next.trailer_size  = '0;
                st_next.byte_count    = '0;
                st_next.phase         = gzfp_pkg::PH_TRAILER;
            end
        end
        else
        begin
            unique case (st.phase)
                gzfp_pkg::PH_HEADER:
                begin
                    res.byte_class = gzfp_pkg::CLS_HEADER;
                    unique case (st.byte_count)
                        16'd0:
                            if (b != gzfp_pkg::GZ_ID1)
                                st_next.error_latch = gzfp_pkg::ERR_ID1;
                        16'd1:
                            if (b != gzfp_pkg::GZ_ID2)
                                st_next.error_latch = gzfp_pkg::ERR_ID2;
                        16'd2:
                            if (b != gzfp_pkg::GZ_CM)
                                st_next.error_latch = gzfp_pkg::ERR_METHOD;
                        16'd3:
                        begin
                            if ((b & gzfp_pkg::GZ_RSVD_MASK) != 8'h00)
                                st_next.error_latch = gzfp_pkg::ERR_RSVD;
                            st_next.member_flags = b[4:0];
                        end
                        16'd8:
                            if (b != gzfp_pkg::GZ_XFL_MAX && b != gzfp_pkg::GZ_XFL_FAST)
                                st_next.error_latch = gzfp_pkg::ERR_XFL;
                        default:
                        begin
                        end
                    endcase
                    if (st.byte_count >= 16'd9)
                    begin
                        st_next.extra_length = '0;
                        st_next.byte_count   = '0;
                        st_next.phase = gzfp_pkg::next_phase(gzfp_pkg::PH_HEADER,
                                                             st.member_flags, 16'd0);
                    end
                    else
                    begin
                        st_next.byte_count = bc_inc;
                    end
                end
                gzfp_pkg::PH_XLEN:
                begin
                    res.byte_class = gzfp_pkg::CLS_HEADER;
                    if (st.byte_count == 16'd0)
                    begin
                        st_next.extra_length = {8'h00, b};
                        st_next.byte_count   = 16'd1;
                    end
                    else
                    begin
                        st_next.extra_length = xlen_full;
                        st_next.byte_count   = '0;
                        st_next.phase = gzfp_pkg::next_phase(gzfp_pkg::PH_XLEN,
                                                             st.member_flags, xlen_full);
                    end
                end
                gzfp_pkg::PH_EXTRA:
                begin
                    res.byte_class     = gzfp_pkg::CLS_HEADER;
                    st_next.byte_count = bc_inc;
                    if (bc_inc >= st.extra_length)
                    begin
                        st_next.byte_count = '0;
                        st_next.phase = gzfp_pkg::next_phase(gzfp_pkg::PH_EXTRA,
                                                             st.member_flags,
                                                             st.extra_length);
                    end
                end
                gzfp_pkg::PH_NAME, gzfp_pkg::PH_COMMENT:
                begin
                    res.byte_class = gzfp_pkg::CLS_HEADER;
                    if (b == 8'h00)
                    begin
                        st_next.byte_count = '0;
                        st_next.phase = gzfp_pkg::next_phase(st.phase, st.member_flags,
                                                             st.extra_length);
                    end
                end
                gzfp_pkg::PH_HCRC:
                begin
                    res.byte_class = gzfp_pkg::CLS_HEADER;
                    if (st.byte_count == 16'd0)
                    begin
                        st_next.byte_count = 16'd1;
                    end
                    else
                    begin
                        st_next.byte_count = '0;
                        st_next.phase = gzfp_pkg::next_phase(gzfp_pkg::PH_HCRC,
                                                             st.member_flags,
                                                             st.extra_length);
                    end
                end
                gzfp_pkg::PH_PAYLOAD:
                begin
                    res.byte_class = gzfp_pkg::CLS_PAYLOAD;
                end
                gzfp_pkg::PH_TRAILER:
                begin
                    res.byte_class       = gzfp_pkg::CLS_TRAILER;
                    st_next.trailer_size = tsz;
                    if (st.byte_count >= 16'd7)
                    begin
                        if (tsz == st.expected_size)
                            res.member_done = 1'b1;
                        else
                            st_next.error_latch = gzfp_pkg::ERR_ISIZE;
                        st_next.phase      = gzfp_pkg::PH_HEADER;
                        st_next.byte_count = '0;
                    end
                    else
                    begin
                        st_next.byte_count = bc_inc;
                    end
                end
            endcase
        end

        res.error_code = st_next.error_latch;
    end

endmodule

// ===== rtl/core/gzfp_out_reg.sv =====
module gzfp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  gzfp_pkg::result_t res_in,
    output logic              busy,
    output logic              result_valid,
    input  logic              result_stall,
    output gzfp_pkg::result_t result
);

    logic              valid_reg;
    logic              valid_next;
    gzfp_pkg::result_t data_reg;

    // full and not being taken this cycle
    assign busy = valid_reg && result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int STREAM_BEATS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 20;

    // one beat of the gzip stream plus a flag that holds it back until the block is drained
    typedef struct {
        gzfp_pkg::item_t it;
        bit              drain;
    } stream_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    gzfp_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    gzfp_pkg::result_t result;

    gzip_member_frame_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pending stream beats and expected parse results
    stream_beat_t      stream_q[$];
    gzfp_pkg::result_t parse_due_q[$];

    int n_parsed   = 0;   // beats accepted by the block, each with an expected result
    int n_seen     = 0;   // results taken from the block
    int n_fail     = 0;
    int n_members  = 0;
    int n_payload  = 0;
    int third      = 1;
    int cycle_cnt  = 0;
    bit stim_done  = 1'b0;
    bit hold_next  = 1'b0;
    bit noisy      = 1'b0;

    // predictor state, mirrors the parser's own registers
    gzfp_pkg::phase_t pr_phase = gzfp_pkg::PH_HEADER;
    logic [15:0]      pr_count = '0;
    logic [4:0]       pr_flags = '0;
    logic [15:0]      pr_xlen = '0;
    logic [31:0]      pr_want_size = '0;
    logic [31:0]      pr_isize = '0;
    logic [2:0]       pr_err = gzfp_pkg::ERR_OK;

    // step past the finished phase to the next one the flags ask for
    function automatic void leave_phase(input gzfp_pkg::phase_t done);
        gzfp_pkg::phase_t p;
        pr_count = '0;
        p = gzfp_pkg::phase_t'(done + 3'd1);
        while (p != gzfp_pkg::PH_PAYLOAD)
        begin
            if (p == gzfp_pkg::PH_XLEN && pr_flags[gzfp_pkg::FLG_EXTRA]) break;
            if (p == gzfp_pkg::PH_EXTRA && pr_flags[gzfp_pkg::FLG_EXTRA] && pr_xlen != 16'd0)
                break;
            if (p == gzfp_pkg::PH_NAME && pr_flags[gzfp_pkg::FLG_NAME]) break;
            if (p == gzfp_pkg::PH_COMMENT && pr_flags[gzfp_pkg::FLG_COMMENT]) break;
            if (p == gzfp_pkg::PH_HCRC && pr_flags[gzfp_pkg::FLG_HCRC]) break;
            p = gzfp_pkg::phase_t'(p + 3'd1);
        end
        pr_phase = p;
    endfunction

    // expected result of one stream beat, advancing the predictor state
    function automatic gzfp_pkg::result_t parse_byte(input gzfp_pkg::item_t it);
        gzfp_pkg::result_t r;
        logic [7:0]        b;
        int                sh;
        b = it.data_byte;
        r.byte_class  = gzfp_pkg::CLS_DROP;
        r.data_out    = it.payload_end ? 8'd0 : b;
        r.member_done = 1'b0;
        if (pr_err != gzfp_pkg::ERR_OK)
        begin
            // sticky error: every beat is dropped
        end
        else if (it.payload_end)
        begin
            // a payload end anywhere but in the payload is ignored
            if (pr_phase == gzfp_pkg::PH_PAYLOAD)
            begin
                pr_want_size = it.inflated_size;
                pr_isize     = '0;
                pr_count     = '0;
                pr_phase     = gzfp_pkg::PH_TRAILER;
            end
        end
        else
        begin
            case (pr_phase)
                gzfp_pkg::PH_HEADER:
                begin
                    r.byte_class = gzfp_pkg::CLS_HEADER;
                    case (pr_count)
                        16'd0: if (b != gzfp_pkg::GZ_ID1) pr_err = gzfp_pkg::ERR_ID1;
                        16'd1: if (b != gzfp_pkg::GZ_ID2) pr_err = gzfp_pkg::ERR_ID2;
                        16'd2: if (b != gzfp_pkg::GZ_CM) pr_err = gzfp_pkg::ERR_METHOD;
                        16'd3:
                        begin
                            if ((b & gzfp_pkg::GZ_RSVD_MASK) != 8'd0)
                                pr_err = gzfp_pkg::ERR_RSVD;
                            pr_flags = b[4:0];
                        end
                        16'd8:
                            if (b != gzfp_pkg::GZ_XFL_MAX && b != gzfp_pkg::GZ_XFL_FAST)
                                pr_err = gzfp_pkg::ERR_XFL;
                        default: ;
                    endcase
                    if (pr_count >= 16'd9)
                    begin
                        pr_xlen = '0;
                        leave_phase(gzfp_pkg::PH_HEADER);
                    end
                    else
                        pr_count = pr_count + 16'd1;
                end
                gzfp_pkg::PH_XLEN:
                begin
                    r.byte_class = gzfp_pkg::CLS_HEADER;
                    if (pr_count == 16'd0)
                    begin
                        pr_xlen  = {8'd0, b};
                        pr_count = 16'd1;
                    end
                    else
                    begin
                        pr_xlen[15:8] = b;
                        leave_phase(gzfp_pkg::PH_XLEN);
                    end
                end
                gzfp_pkg::PH_EXTRA:
                begin
                    r.byte_class = gzfp_pkg::CLS_HEADER;
                    pr_count = pr_count + 16'd1;
                    if (pr_count >= pr_xlen) leave_phase(gzfp_pkg::PH_EXTRA);
                end
                gzfp_pkg::PH_NAME, gzfp_pkg::PH_COMMENT:
                begin
                    r.byte_class = gzfp_pkg::CLS_HEADER;
                    if (b == 8'd0) leave_phase(pr_phase);
                end
                gzfp_pkg::PH_HCRC:
                begin
                    r.byte_class = gzfp_pkg::CLS_HEADER;
                    if (pr_count == 16'd0) pr_count = 16'd1;
                    else leave_phase(gzfp_pkg::PH_HCRC);
                end
                gzfp_pkg::PH_PAYLOAD:
                    r.byte_class = gzfp_pkg::CLS_PAYLOAD;
                gzfp_pkg::PH_TRAILER:
                begin
                    r.byte_class = gzfp_pkg::CLS_TRAILER;
                    // crc32 is skipped, isize arrives little-endian in the last four bytes
                    if (pr_count >= 16'd4)
                    begin
                        sh = int'((pr_count - 16'd4) & 16'd3) * 8;
                        pr_isize[sh +: 8] = b;
                    end
                    if (pr_count >= 16'd7)
                    begin
                        if (pr_isize == pr_want_size) r.member_done = 1'b1;
                        else pr_err = gzfp_pkg::ERR_ISIZE;
                        pr_phase = gzfp_pkg::PH_HEADER;
                        pr_count = '0;
                    end
                    else
                        pr_count = pr_count + 16'd1;
                end
                default:
                begin
                    pr_phase = gzfp_pkg::PH_HEADER;
                    pr_count = '0;
                end
            endcase
        end
        r.error_code = pr_err;
        return r;
    endfunction

    // idle percentage: sender light and receiver heavy, then swapped, then none
    function automatic int idle_pct(input bit rx_side);
        if (n_parsed < third) return rx_side ? 55 : 9;
        else if (n_parsed < 2 * third) return rx_side ? 9 : 55;
        else return 0;
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic pend, input logic [31:0] size);
        stream_beat_t s;
        s.it.data_byte     = b;
        s.it.payload_end   = pend;
        s.it.inflated_size = size;
        s.drain            = hold_next;
        hold_next          = 1'b0;
        stream_q.push_back(s);
    endtask

    // a byte outside the payload, now and then preceded by a stray payload end
    task automatic add_byte(input logic [7:0] b);
        if (noisy && $urandom_range(19) == 0) add_beat(8'($urandom), 1'b1, $urandom);
        add_beat(b, 1'b0, $urandom);
    endtask

    // one well-formed member apart from the isize written into the trailer
    task automatic add_member(input logic [4:0] flg, input logic [7:0] xfl,
                              input logic [15:0] xlen, input int name_len, input int cmt_len,
                              input int pay_len, input logic [31:0] size,
                              input logic [31:0] isize);
        add_byte(gzfp_pkg::GZ_ID1);
        add_byte(gzfp_pkg::GZ_ID2);
        add_byte(gzfp_pkg::GZ_CM);
        add_byte({3'b000, flg});
        repeat (4) add_byte(8'($urandom));   // mtime
        add_byte(xfl);
        add_byte(8'($urandom));              // os
        if (flg[gzfp_pkg::FLG_EXTRA])
        begin
            add_byte(xlen[7:0]);
            add_byte(xlen[15:8]);
            repeat (xlen) add_byte(8'($urandom));
        end
        if (flg[gzfp_pkg::FLG_NAME])
        begin
            repeat (name_len) add_byte(8'($urandom_range(255, 1)));
            add_byte(8'd0);
        end
        if (flg[gzfp_pkg::FLG_COMMENT])
        begin
            repeat (cmt_len) add_byte(8'($urandom_range(255, 1)));
            add_byte(8'd0);
        end
        if (flg[gzfp_pkg::FLG_HCRC]) repeat (2) add_byte(8'($urandom));
        // payload beats go straight in: a stray end here would cut the payload short
        repeat (pay_len) add_beat(8'($urandom), 1'b0, $urandom);
        add_beat(8'($urandom), 1'b1, size);
        repeat (4) add_byte(8'($urandom));   // crc32, not checked by the block
        for (int i = 0; i < 4; i++) add_byte(isize[8*i +: 8]);
    endtask

    // driver: predicts each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        gzfp_pkg::result_t due;
        bit                took;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            took = item_valid && !item_stall;
            if (took)
            begin
                due = parse_byte(item);
                parse_due_q.push_back(due);
                n_parsed <= n_parsed + 1;
                if (due.member_done) n_members++;
                if (due.byte_class == gzfp_pkg::CLS_PAYLOAD && due.error_code == gzfp_pkg::ERR_OK)
                    n_payload++;
            end
            // a stalled beat stays put; otherwise the slot is free for the next one
            if (!item_valid || took)
            begin
                if (stream_q.size() == 0)
                begin
                    item_valid <= 1'b0;
                    stim_done  <= 1'b1;
                end
                else if ($urandom_range(99) < idle_pct(1'b0) ||
                         (stream_q[0].drain && (took || n_seen != n_parsed)))
                    item_valid <= 1'b0;
                else
                begin
                    item       <= stream_q[0].it;
                    item_valid <= 1'b1;
                    stream_q.pop_front();
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        gzfp_pkg::result_t due;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (n_seen == n_parsed)
                begin
                    $error("result beat with no expected result waiting");
                    n_fail++;
                end
                else
                begin
                    due = parse_due_q.pop_front();
                    if (result.byte_class !== due.byte_class)
                    begin
                        $error("byte_class: expected %0d, got %0d",
                               due.byte_class, result.byte_class);
                        n_fail++;
                    end
                    if (result.data_out !== due.data_out)
                    begin
                        $error("data_out: expected %0h, got %0h", due.data_out, result.data_out);
                        n_fail++;
                    end
                    if (result.member_done !== due.member_done)
                    begin
                        $error("member_done: expected %0d, got %0d",
                               due.member_done, result.member_done);
                        n_fail++;
                    end
                    if (result.error_code !== due.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d",
                               due.error_code, result.error_code);
                        n_fail++;
                    end
                    n_seen <= n_seen + 1;
                end
            end
            result_stall <= ($urandom_range(99) < idle_pct(1'b1));
        end
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("gzip_member_frame_parser test failed");
        $finish;
    end

    initial
    begin
        logic [2:0]  err_pick;
        logic [7:0]  hdr [10];
        logic [31:0] size;
        logic [15:0] xlen;
        bit          drain_done;
        drain_done = 1'b0;

        // directed: a stray payload end before any header, at the field maxima
        add_beat(8'hff, 1'b1, 32'hffff_ffff);
        // smallest member, one random payload byte, isize all ones
        add_member(5'h00, gzfp_pkg::GZ_XFL_MAX, 16'd0, 0, 0, 1, 32'hffff_ffff, 32'hffff_ffff);
        // every flag, zero extra length, empty name, one-character comment, empty payload
        add_member(5'h1f, gzfp_pkg::GZ_XFL_FAST, 16'd0, 0, 1, 0, 32'd0, 32'd0);

        // random well-formed members with stray payload ends in between
        noisy = 1'b1;
        while (stream_q.size() < STREAM_BEATS - 40)
        begin
            if (!drain_done && stream_q.size() > STREAM_BEATS / 2)
            begin
                hold_next  = 1'b1;
                drain_done = 1'b1;
            end
            // now and then an extra field long enough to need the high length byte
            if ($urandom_range(24) == 0) xlen = 16'($urandom_range(270, 256));
            else xlen = 16'($urandom_range(6, 0));
            size = $urandom;
            add_member(5'($urandom),
                       $urandom_range(1) ? gzfp_pkg::GZ_XFL_MAX : gzfp_pkg::GZ_XFL_FAST,
                       xlen, $urandom_range(6, 0), $urandom_range(6, 0),
                       $urandom_range(12, 0), size, size);
        end

        // errors stick until reset, so the run closes on one failure picked at random
        err_pick = 3'($urandom_range(6, 1));
        if (err_pick == gzfp_pkg::ERR_ISIZE)
        begin
            size = $urandom;
            add_member(5'($urandom), gzfp_pkg::GZ_XFL_MAX, 16'd2, 2, 2, 3, size,
                       size ^ (32'd1 << $urandom_range(31)));
        end
        else
        begin
            hdr[0] = gzfp_pkg::GZ_ID1;
            hdr[1] = gzfp_pkg::GZ_ID2;
            hdr[2] = gzfp_pkg::GZ_CM;
            hdr[3] = {3'b000, 5'($urandom)};
            for (int i = 4; i < 10; i++) hdr[i] = 8'($urandom);
            hdr[8] = gzfp_pkg::GZ_XFL_FAST;
            case (err_pick)
                gzfp_pkg::ERR_ID1:
                    do hdr[0] = 8'($urandom); while (hdr[0] == gzfp_pkg::GZ_ID1);
                gzfp_pkg::ERR_ID2:
                    do hdr[1] = 8'($urandom); while (hdr[1] == gzfp_pkg::GZ_ID2);
                gzfp_pkg::ERR_METHOD:
                    do hdr[2] = 8'($urandom); while (hdr[2] == gzfp_pkg::GZ_CM);
                gzfp_pkg::ERR_RSVD:
                    hdr[3] = {3'($urandom_range(7, 1)), 5'($urandom)};
                default:
                    do hdr[8] = 8'($urandom);
                    while (hdr[8] == gzfp_pkg::GZ_XFL_MAX || hdr[8] == gzfp_pkg::GZ_XFL_FAST);
            endcase
            for (int i = 0; i < 10; i++) add_byte(hdr[i]);
        end
        // everything after the failure must come out dropped
        repeat (30) add_beat(8'($urandom), $urandom_range(3) == 0, $urandom);

        third = stream_q.size() / 3;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (!stim_done || n_seen != n_parsed) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d beats parsed: %0d members closed, %0d payload bytes passed",
                 n_parsed, n_members, n_payload);
        $display("stream ended on sticky error code %0d, with idle and drain phases", pr_err);
        if (n_fail == 0)
            $display("gzip_member_frame_parser test passed");
        else
            $display("gzip_member_frame_parser test failed");
        $finish;
    end

endmodule
